[design/pdts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pdts_pkg;

    localparam int NUM_VOICES      = 13;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_WRAP     = 800000;

    localparam int VOICE_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SINE_LEN  = 1 << SINE_TABLE_BITS;
    localparam int IDX_W     = 20;
    localparam int AMP_W     = 31;
    localparam int ENV_W     = 17;
    localparam int SINE_W    = 16;
    localparam int MAG_W     = 15;
    localparam int PROD_W    = AMP_W + ENV_W - 1;
    localparam int PART_W    = AMP_W + MAG_W;
    localparam int ACC_W     = AMP_W + VOICE_W + 2;
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 31;
    localparam int NOTE_COUNT = 13;

    localparam logic [AMP_W-1:0] AMP_RESET   = 31'd165191049;
    localparam logic [ENV_W-1:0] DECAY_RESET = 17'd26;
    localparam logic [ENV_W-1:0] ENV_FULL    = 17'd65536;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    localparam logic [7:0] NOTE_KEYS [NOTE_COUNT] = '{
        8'h10, 8'h03, 8'h11, 8'h04, 8'h12, 8'h13, 8'h06,
        8'h14, 8'h07, 8'h15, 8'h08, 8'h16, 8'h17
    };

    localparam logic [31:0] NOTE_STEPS [NOTE_COUNT] = '{
        32'd140459389, 32'd148811490, 32'd157660196, 32'd167035036, 32'd176967685,
        32'd187490355, 32'd198639016, 32'd210450713, 32'd222965174, 32'd236223201,
        32'd250269892, 32'd265151417, 32'd280918242
    };

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_AMP   = 1'b0,
        CFG_DECAY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic               tick_start;
        logic               key_wr;
        logic               key_press;
        logic [7:0]         key_code;
        logic               voice_vld;
        logic [VOICE_W-1:0] voice_idx;
        logic               out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic               hit;
        logic [VOICE_W-1:0] voice;
    } t_key_hit;

    typedef logic signed [SINE_W-1:0] t_sine_rom [SINE_LEN];

    function automatic t_key_hit key_to_voice(input logic [7:0] key);
        t_key_hit res;
        logic     found;
        res   = '0;
        found = 1'b0;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            if (!found && NOTE_KEYS[n] == key) begin
                found = 1'b1;
                if (n < NUM_VOICES) begin
                    res.hit   = 1'b1;
                    res.voice = VOICE_W'(n);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] voice_step(input logic [VOICE_W-1:0] v);
        logic [31:0] step;
        step = '0;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            if (n < NUM_VOICES && VOICE_W'(n) == v) begin
                step = NOTE_STEPS[n];
            end
        end
        return step;
    endfunction

    function automatic logic signed [SINE_W-1:0] sine_entry(input int i);
        int          qbits;
        logic [63:0] quarter;
        logic [1:0]  quad;
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] val;
        qbits   = SINE_TABLE_BITS - 2;
        quarter = 64'd1 << qbits;
        quad    = 2'((i >> qbits) & 3);
        j       = 64'(i) & (quarter - 64'd1);
        if (quad[0]) begin
            j = quarter - j;
        end
        x    = (HALF_PI_Q30 * j) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        val = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (val > 64'd32767) begin
            val = 64'd32767;
        end
        if (quad[1]) begin
            return -$signed(SINE_W'(val));
        end
        return $signed(SINE_W'(val));
    endfunction

    function automatic t_sine_rom sine_rom_build();
        t_sine_rom rom;
        for (int i = 0; i < SINE_LEN; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

[design/pdts_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pdts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] key_code;

    modport source (output valid, output op, output key_code, input ready);
    modport sink (input valid, input op, input key_code, output ready);
endinterface

`default_nettype wire

[design/pdts_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pdts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

[design/pdts_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none

module pdts_sine_rom (
    input  wire logic                                 i_clk,
    input  wire logic [pdts_pkg::SINE_TABLE_BITS-1:0] i_addr,
    output logic signed [pdts_pkg::SINE_W-1:0]        o_data
);

    localparam pdts_pkg::t_sine_rom SINE_ROM = pdts_pkg::sine_rom_build();

    logic signed [pdts_pkg::SINE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[design/pdts_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pdts_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_op,
    input  wire logic [7:0]        i_in_key_code,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output pdts_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    t_state                         r_state;
    logic [pdts_pkg::VOICE_W-1:0]   r_voice;
    logic                           r_drain;
    logic                           r_out_valid;
    logic                           in_acc;
    logic                           out_load;

    // no word is taken while reset is held
    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd            = '0;
        o_cmd.tick_start = in_acc && (i_in_op == pdts_pkg::OP_TICK);
        o_cmd.key_wr     = in_acc && ((i_in_op == pdts_pkg::OP_PRESS)
                                   || (i_in_op == pdts_pkg::OP_RELEASE));
        o_cmd.key_press  = (i_in_op == pdts_pkg::OP_PRESS);
        o_cmd.key_code   = i_in_key_code;
        o_cmd.voice_vld  = (r_state == ST_RUN);
        o_cmd.voice_idx  = r_voice;
        o_cmd.out_load   = out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_voice     <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in_op == pdts_pkg::OP_TICK)) begin
                        r_state <= ST_RUN;
                        r_voice <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_voice == pdts_pkg::VOICE_W'(pdts_pkg::NUM_VOICES - 1)) begin
                        r_state <= ST_DRAIN;
                        r_drain <= 1'b0;
                    end else begin
                        r_voice <= r_voice + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (r_drain) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_drain <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[design/pdts_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module pdts_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [pdts_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire pdts_pkg::t_dp_cmd                i_cmd,
    output logic signed [pdts_pkg::SAMPLE_W-1:0]  o_sample
);

    localparam int AMP_W  = pdts_pkg::AMP_W;
    localparam int ENV_W  = pdts_pkg::ENV_W;
    localparam int ACC_W  = pdts_pkg::ACC_W;
    localparam int PROD_W = pdts_pkg::PROD_W;
    localparam int PART_W = pdts_pkg::PART_W;
    localparam int MAG_W  = pdts_pkg::MAG_W;
    localparam int NV     = pdts_pkg::NUM_VOICES;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, 31'd0};

    logic [AMP_W-1:0]            r_amp;
    logic [ENV_W-1:0]            r_decay;
    logic [pdts_pkg::IDX_W-1:0]  r_idx;
    logic                        r_wrap;
    logic [31:0]                 r_phase [NV];
    logic [ENV_W-1:0]            r_env [NV];
    logic [NV-1:0]               r_held;
    logic [PROD_W-1:0]           r_prod;
    logic                        r_full;
    logic                        r_s1_vld;
    logic [PART_W-1:0]           r_part;
    logic                        r_part_neg;
    logic                        r_s2_vld;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [31:0]          r_sample;

    logic [pdts_pkg::IDX_W-1:0]  n_idx;
    logic [31:0]                 n_phase;
    logic [ENV_W-1:0]            env_eff;
    logic [ENV_W-1:0]            n_env;
    logic [PROD_W-1:0]           n_prod;
    logic signed [pdts_pkg::SINE_W-1:0] sine;
    logic [MAG_W-1:0]            mag;
    logic [AMP_W-1:0]            amp_env;
    logic [PART_W-1:0]           n_part;
    logic [ACC_W-1:0]            part_ext;
    logic signed [31:0]          sat;
    pdts_pkg::t_key_hit          key_hit;

    assign key_hit = pdts_pkg::key_to_voice(i_cmd.key_code);
    assign n_idx   = r_idx + 1'b1;

    // stage 0: phase advance, envelope and amplitude scaling
    always_comb begin
        n_phase = r_wrap ? 32'd0
                         : r_phase[i_cmd.voice_idx] + pdts_pkg::voice_step(i_cmd.voice_idx);
        env_eff = r_held[i_cmd.voice_idx] ? pdts_pkg::ENV_FULL : r_env[i_cmd.voice_idx];
        n_env   = (env_eff > r_decay) ? env_eff - r_decay : '0;
        n_prod  = {{(ENV_W-1){1'b0}}, r_amp} * {{AMP_W{1'b0}}, env_eff[ENV_W-2:0]};
    end

    pdts_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (n_phase[31 -: pdts_pkg::SINE_TABLE_BITS]),
        .o_data (sine)
    );

    // stage 1: times sine magnitude
    always_comb begin
        mag     = sine[pdts_pkg::SINE_W-1] ? MAG_W'(-sine) : MAG_W'(sine);
        amp_env = r_full ? r_amp : r_prod[PROD_W-1:ENV_W-1];
        n_part  = {{MAG_W{1'b0}}, amp_env} * {{AMP_W{1'b0}}, mag};
    end

    // stage 2: accumulate and saturate
    always_comb begin
        part_ext = {{(ACC_W-(PART_W-15)){1'b0}}, r_part[PART_W-1:15]};
        if (r_acc > SAT_HI) begin
            sat = 32'sh7FFFFFFF;
        end else if (r_acc < SAT_LO) begin
            sat = 32'sh80000000;
        end else begin
            sat = r_acc[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp    <= pdts_pkg::AMP_RESET;
            r_decay  <= pdts_pkg::DECAY_RESET;
            r_idx    <= '0;
            r_wrap   <= 1'b0;
            r_held   <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            for (int v = 0; v < NV; v++) begin
                r_phase[v] <= '0;
                r_env[v]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pdts_pkg::CFG_AMP:   r_amp   <= i_cfg_data[AMP_W-1:0];
                    pdts_pkg::CFG_DECAY: r_decay <= i_cfg_data[ENV_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.key_wr && key_hit.hit) begin
                r_held[key_hit.voice] <= i_cmd.key_press;
            end
            if (i_cmd.tick_start) begin
                if (n_idx >= pdts_pkg::IDX_W'(pdts_pkg::SAMPLE_WRAP)) begin
                    r_idx  <= '0;
                    r_wrap <= 1'b1;
                end else begin
                    r_idx  <= n_idx;
                    r_wrap <= 1'b0;
                end
            end
            if (i_cmd.voice_vld) begin
                r_phase[i_cmd.voice_idx] <= n_phase;
                r_env[i_cmd.voice_idx]   <= n_env;
            end
            r_s1_vld <= i_cmd.voice_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_full     <= env_eff[ENV_W-1];
        r_part     <= n_part;
        r_part_neg <= sine[pdts_pkg::SINE_W-1];
        if (i_cmd.tick_start) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_part_neg ? r_acc - $signed(part_ext) : r_acc + $signed(part_ext);
        end
        if (i_cmd.out_load) begin
            r_sample <= sat;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

[design/polyphonic_decay_tone_synth.sv]
// channel     | dir | word                 | accepted when
// ------------+-----+----------------------+----------------------
// i_in_word   | in  | op, key_code         | valid && ready
// o_out_word  | out | sample (signed 32)   | valid && ready
// cfg         | in  | i_cfg_idx, i_cfg_data| i_cfg_we
//
// key press and release words give no output word
// a tick runs in order: accept, one voice per cycle over 13 voices through
// the shared multiply pipeline, pipeline drain, output load
// a tick stalls in its last cycle until the output register is free
// synchronous active-low reset restores the register defaults and clears all voices
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_decay_tone_synth (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    pdts_in_if.sink                         i_in_word,
    pdts_out_if.source                      o_out_word,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [pdts_pkg::CFG_W-1:0] i_cfg_data
);

    pdts_pkg::t_dp_cmd cmd;

    pdts_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_word.valid),
        .i_in_op       (i_in_word.op),
        .i_in_key_code (i_in_word.key_code),
        .o_in_ready    (i_in_word.ready),
        .i_out_ready   (o_out_word.ready),
        .o_out_valid   (o_out_word.valid),
        .o_cmd         (cmd)
    );

    pdts_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sample   (o_out_word.sample)
    );

endmodule

`default_nettype wire
